// ===== sv/brms_pkg.sv =====
// ----------------------------------------------------------------------------
// brms_pkg
// Shared sizes, types and the storage request bundle for the bucketed
// range-maximum store.
// ----------------------------------------------------------------------------
package brms_pkg;

  localparam int POSITIONS    = 1024;
  localparam int BUCKET_SHIFT = 5;
  localparam int BUCKET_SIZE  = 1 << BUCKET_SHIFT;
  localparam int VALUE_BITS   = 16;

  // Fixed widths of the beat fields.
  localparam int IN_POS_W = 10;
  localparam int LEVEL_W  = 16;
  localparam int QVAL_W   = 16;

  localparam int BUCKET_COUNT = (POSITIONS + BUCKET_SIZE - 1) / BUCKET_SIZE;
  localparam int POS_W        = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int CMP_W        = ((IN_POS_W > POS_W) ? IN_POS_W : POS_W) + 1;

  // Codes carried by the kind field of an input beat.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [BKT_W-1:0]      bkt_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  typedef struct packed {
    logic cell_rd_en;
    pos_t cell_rd_addr;
    logic cell_wr_en;
    pos_t cell_wr_addr;
    val_t cell_wr_data;
    bkt_t tag_addr;
    logic tag_wr_en;
    val_t tag_wr_data;
  } store_req_t;

endpackage

// ===== sv/brms_max_unit.sv =====
// ----------------------------------------------------------------------------
// brms_max_unit
// Shared compare-and-select unit: returns the larger of two values.
// ----------------------------------------------------------------------------
module brms_max_unit (
  input  brms_pkg::val_t opa,
  input  brms_pkg::val_t opb,
  output brms_pkg::val_t max_val
);
  import brms_pkg::*;

  assign max_val = (opa > opb) ? opa : opb;

endmodule

// ===== sv/brms_store.sv =====
// ----------------------------------------------------------------------------
// brms_store
// Per-position cell memory with a registered read port, and the per-bucket
// tag array in flip-flops.
// ----------------------------------------------------------------------------
module brms_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  brms_pkg::store_req_t  req,
  output brms_pkg::val_t        cell_rd_data,
  output brms_pkg::val_t        tag_rd_data
);
  import brms_pkg::*;

  val_t cell_mem [POSITIONS];
  val_t tag_r [BUCKET_COUNT];
  val_t cell_rd_data_r;

  // The cell memory has no reset; the sequencer sweeps it to zero instead.
  always_ff @(posedge clk) begin
    if (req.cell_wr_en) begin
      cell_mem[req.cell_wr_addr] <= req.cell_wr_data;
    end
    if (req.cell_rd_en) begin
      cell_rd_data_r <= cell_mem[req.cell_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        tag_r[i] <= '0;
      end
    end else if (req.tag_wr_en) begin
      tag_r[req.tag_addr] <= req.tag_wr_data;
    end
  end

  assign cell_rd_data = cell_rd_data_r;
  assign tag_rd_data  = tag_r[req.tag_addr];

endmodule

// ===== sv/bucketed_range_max_store.sv =====
// ----------------------------------------------------------------------------
// bucketed_range_max_store
// Range "raise to at least" updates and point queries over a bucketed array,
// run by a sequencer around one shared compare-and-select unit.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Ports
//  -------  ---------------------  ------------------------------------------
//  input    start & !busy          in_kind, in_range_start, in_range_end,
//                                  in_level, in_query_position
//  result   out_valid (one cycle)  out_query_value
//
// An update raises each cell of the first end bucket, then the tag of each
// whole bucket between, then each cell of the last end bucket, paced by the
// single cell memory port and the shared max unit. A query reads the cell,
// then registers the larger of it and its bucket tag; an out-of-range query
// returns zero. After reset, with busy high, the cell memory is swept to zero,
// one entry per cycle. Skipped updates are dropped. Results cannot be stalled.
// ----------------------------------------------------------------------------
module bucketed_range_max_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [brms_pkg::IN_POS_W-1:0] in_range_start,
  input  logic [brms_pkg::IN_POS_W-1:0] in_range_end,
  input  logic [brms_pkg::LEVEL_W-1:0]  in_level,
  input  logic [brms_pkg::IN_POS_W-1:0] in_query_position,
  output logic                         out_valid,
  output logic [brms_pkg::QVAL_W-1:0]   out_query_value
);
  import brms_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRD,
    ST_QOUT,
    ST_CELL,
    ST_TAG
  } state_t;

  localparam pos_t BKT_MASK    = POS_W'(BUCKET_SIZE - 1);
  localparam pos_t LAST_POS    = POS_W'(POSITIONS - 1);

  state_t state_r, state_nxt;
  pos_t   clr_ptr_r, clr_ptr_nxt;
  pos_t   cur_r, cur_nxt;
  pos_t   hi_r, hi_nxt;
  pos_t   end_r, end_nxt;
  pos_t   pend_addr_r, pend_addr_nxt;
  pos_t   qpos_r, qpos_nxt;
  logic   issue_r, issue_nxt;
  logic   pend_r, pend_nxt;
  logic   second_r, second_nxt;
  bkt_t   bkt_r, bkt_nxt;
  bkt_t   last_b_r, last_b_nxt;
  val_t   lvl_r, lvl_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [QVAL_W-1:0] out_value_r, out_value_nxt;

  store_req_t req;
  val_t       cell_rd_data;
  val_t       tag_rd_data;
  val_t       opa, opb, max_val;

  logic [CMP_W-1:0] start_w, end_w;
  logic             upd_skip, query_oob, single;
  pos_t             start_p, end_p;
  bkt_t             first_b, last_b;

  brms_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .cell_rd_data (cell_rd_data),
    .tag_rd_data  (tag_rd_data)
  );

  brms_max_unit u_max (
    .opa     (opa),
    .opb     (opb),
    .max_val (max_val)
  );

  // Decode of an incoming beat.
  always_comb begin
    start_w   = CMP_W'(in_range_start);
    end_w     = CMP_W'(in_range_end);
    upd_skip  = (start_w > end_w) || (start_w >= CMP_W'(POSITIONS));
    query_oob = CMP_W'(in_query_position) >= CMP_W'(POSITIONS);
    start_p   = POS_W'(in_range_start);
    end_p     = (end_w >= CMP_W'(POSITIONS)) ? LAST_POS : POS_W'(in_range_end);
    first_b   = BKT_W'(start_p >> BUCKET_SHIFT);
    last_b    = BKT_W'(end_p >> BUCKET_SHIFT);
    single    = (first_b == last_b);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_ptr_nxt   = clr_ptr_r;
    cur_nxt       = cur_r;
    hi_nxt        = hi_r;
    end_nxt       = end_r;
    pend_addr_nxt = pend_addr_r;
    qpos_nxt      = qpos_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    second_nxt    = second_r;
    bkt_nxt       = bkt_r;
    last_b_nxt    = last_b_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;

    req          = '0;
    req.tag_addr = bkt_r;
    opa          = cell_rd_data;
    opb          = lvl_r;

    unique case (state_r)
      ST_CLEAR: begin
        req.cell_wr_en   = 1'b1;
        req.cell_wr_addr = clr_ptr_r;
        req.cell_wr_data = '0;
        clr_ptr_nxt      = clr_ptr_r + 1'b1;
        if (clr_ptr_r == LAST_POS) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (in_kind == KIND_UPDATE) begin
            if (!upd_skip) begin
              lvl_nxt    = VALUE_BITS'(in_level);
              cur_nxt    = start_p;
              hi_nxt     = single ? end_p : (start_p | BKT_MASK);
              end_nxt    = end_p;
              second_nxt = single;
              bkt_nxt    = BKT_W'(first_b + 1'b1);
              last_b_nxt = last_b;
              issue_nxt  = 1'b1;
              pend_nxt   = 1'b0;
              state_nxt  = ST_CELL;
            end
          end else if (query_oob) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
          end else begin
            qpos_nxt  = POS_W'(in_query_position);
            state_nxt = ST_QRD;
          end
        end
      end

      ST_QRD: begin
        req.cell_rd_en   = 1'b1;
        req.cell_rd_addr = qpos_r;
        state_nxt        = ST_QOUT;
      end

      ST_QOUT: begin
        req.tag_addr  = BKT_W'(qpos_r >> BUCKET_SHIFT);
        opa           = cell_rd_data;
        opb           = tag_rd_data;
        out_valid_nxt = 1'b1;
        out_value_nxt = QVAL_W'(max_val);
        state_nxt     = ST_IDLE;
      end

      ST_CELL: begin
        // Read one cell ahead while the previous one is raised and written.
        req.cell_rd_en   = issue_r;
        req.cell_rd_addr = cur_r;
        req.cell_wr_en   = pend_r;
        req.cell_wr_addr = pend_addr_r;
        req.cell_wr_data = max_val;
        pend_nxt         = issue_r;
        pend_addr_nxt    = cur_r;
        if (issue_r) begin
          cur_nxt = cur_r + 1'b1;
          if (cur_r == hi_r) begin
            issue_nxt = 1'b0;
          end
        end else begin
          // The last write of this pass happens now.
          if (second_r) begin
            state_nxt = ST_IDLE;
          end else if (bkt_r == last_b_r) begin
            cur_nxt    = end_r & ~BKT_MASK;
            hi_nxt     = end_r;
            second_nxt = 1'b1;
            issue_nxt  = 1'b1;
          end else begin
            state_nxt = ST_TAG;
          end
        end
      end

      ST_TAG: begin
        opa             = tag_rd_data;
        req.tag_wr_en   = 1'b1;
        req.tag_wr_data = max_val;
        bkt_nxt         = BKT_W'(bkt_r + 1'b1);
        if (BKT_W'(bkt_r + 1'b1) == last_b_r) begin
          cur_nxt    = end_r & ~BKT_MASK;
          hi_nxt     = end_r;
          second_nxt = 1'b1;
          issue_nxt  = 1'b1;
          pend_nxt   = 1'b0;
          state_nxt  = ST_CELL;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_ptr_r   <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    hi_r        <= hi_nxt;
    end_r       <= end_nxt;
    pend_addr_r <= pend_addr_nxt;
    qpos_r      <= qpos_nxt;
    second_r    <= second_nxt;
    bkt_r       <= bkt_nxt;
    last_b_r    <= last_b_nxt;
    lvl_r       <= lvl_nxt;
    out_value_r <= out_value_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_query_value = out_value_r;

endmodule
